[sv/idll_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the indexed doubly linked list core.
// No dependencies.
package idll_pkg;

    localparam int CMD_W   = 4;
    localparam int POS_W   = 7;
    localparam int DATA_W  = 32;
    localparam int CNT_O_W = 7;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PREPEND   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_GET       = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SET       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DEL_AT    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic val;
        logic nxt;
        logic prv;
    } t_node_we;

    typedef struct packed {
        logic pop;
        logic push;
        logic clear;
    } t_alloc_ctl;

endpackage

[sv/indexed_doubly_linked_list_core.sv]
`timescale 1ns / 1ps
// Indexed doubly linked list core. Uses idll_pkg, idll_node_mem, idll_slot_alloc.
// Get, set, deletes and middle inserts walk k links from the nearer end
// (k <= count/2); clear, rejects and end inserts walk none. One command at a
// time; the walk through the node memory sets the rate. A result waits in the
// output register while the next command runs.
// Synchronous reset gives an empty list; no memory clearing pass is needed.
module indexed_doubly_linked_list_core
    import idll_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [39:0]  i_s_axis_tdata,   // position[6:0], item_value[38:7]
    input  logic [3:0]   i_s_axis_tuser,   // command[3:0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [103:0] o_m_axis_tdata,   // read_value, element_count, first, last
    output logic [1:0]   o_m_axis_tuser    // status[1:0]
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int WW = (LW > POS_W) ? LW : POS_W;
    localparam logic [LW-1:0] NULL_SLOT = LW'(CAPACITY);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EV   = 4'd3;
    localparam logic [3:0] S_INSA = 4'd4;
    localparam logic [3:0] S_INSB = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_HD   = 4'd7;
    localparam logic [3:0] S_TL   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]              r_state;
    logic [CMD_W-1:0]        r_cmd;
    logic [POS_W-1:0]        r_pos;
    logic signed [DATA_W-1:0] r_val;
    logic [LW-1:0]           r_head, r_tail, r_count;
    logic [LW-1:0]           r_cur, r_steps, r_bef, r_aft, r_new;
    logic                    r_dir;
    logic [STAT_W-1:0]       r_status;
    logic [DATA_W-1:0]       r_readv, r_first, r_last;
    logic                    r_ovalid;
    logic [STAT_W-1:0]       r_o_status;
    logic [DATA_W-1:0]       r_o_readv, r_o_first, r_o_last;
    logic [CNT_O_W-1:0]      r_o_count;

    t_node_we                we;
    t_alloc_ctl              actl;
    logic [IW-1:0]           val_addr, nxt_addr, prv_addr, rd_addr;
    logic [LW-1:0]           nxt_data, prv_data;
    logic [VALUE_BITS-1:0]   val_data, rd_val;
    logic [LW-1:0]           rd_nxt, rd_prv, link, new_slot;
    logic [DATA_W-1:0]       rd_val32;

    logic [WW-1:0]           pos_w, cnt_w, ins_tgt, del_tgt, loc_tgt;
    logic                    is_ins, is_del, loc_dir;
    logic [LW-1:0]           loc_steps;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tdata  = {1'b0, r_o_last, r_o_first, r_o_count, r_o_readv};

    assign link     = r_dir ? rd_nxt : rd_prv;
    assign rd_val32 = DATA_W'(signed'(rd_val));

    idll_node_mem #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_mem (
        .i_clk(i_clk), .i_we(we),
        .i_val_addr(val_addr), .i_val_data(val_data),
        .i_nxt_addr(nxt_addr), .i_nxt_data(nxt_data),
        .i_prv_addr(prv_addr), .i_prv_data(prv_data),
        .i_rd_addr(rd_addr), .o_rd_val(rd_val), .o_rd_nxt(rd_nxt), .o_rd_prv(rd_prv)
    );

    idll_slot_alloc #(.CAPACITY(CAPACITY)) u_alloc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(actl),
        .i_push_slot(r_cur[IW-1:0]), .o_slot(new_slot)
    );

    // command decode and walk setup
    always_comb begin
        pos_w   = WW'(r_pos);
        cnt_w   = WW'(r_count);
        is_ins  = (r_cmd == CMD_APPEND) || (r_cmd == CMD_PREPEND) || (r_cmd == CMD_INSERT);
        is_del  = (r_cmd == CMD_DEL_FIRST) || (r_cmd == CMD_DEL_LAST) ||
                  (r_cmd == CMD_DEL_AT);
        ins_tgt = (r_cmd == CMD_APPEND) ? cnt_w : ((r_cmd == CMD_PREPEND) ? '0 : pos_w);
        del_tgt = (r_cmd == CMD_DEL_FIRST) ? '0 :
                  ((r_cmd == CMD_DEL_LAST) ? cnt_w - WW'(1) : pos_w);
        loc_tgt = is_ins ? ins_tgt - WW'(1) : (is_del ? del_tgt : pos_w);
        loc_dir = loc_tgt < (cnt_w >> 1);
        loc_steps = loc_dir ? LW'(loc_tgt) : LW'(cnt_w - WW'(1) - loc_tgt);
    end

    // memory and allocator control
    always_comb begin
        we       = '0;
        actl     = '0;
        val_addr = r_cur[IW-1:0];
        val_data = VALUE_BITS'(r_val);
        nxt_addr = r_bef[IW-1:0];
        nxt_data = r_new;
        prv_addr = r_aft[IW-1:0];
        prv_data = r_new;
        rd_addr  = r_cur[IW-1:0];
        case (r_state)
            S_DEC: begin
                actl.clear = (r_cmd == CMD_CLEAR);
            end
            S_EV: begin
                if (r_steps != '0) begin
                    rd_addr = link[IW-1:0];
                end else if (r_cmd == CMD_SET) begin
                    we.val = 1'b1;
                end else if (is_del) begin
                    we.nxt    = (rd_prv != NULL_SLOT);
                    nxt_addr  = rd_prv[IW-1:0];
                    nxt_data  = rd_nxt;
                    we.prv    = (rd_nxt != NULL_SLOT);
                    prv_addr  = rd_nxt[IW-1:0];
                    prv_data  = rd_prv;
                    actl.push = 1'b1;
                end
            end
            S_INSA: begin
                actl.pop = 1'b1;
                we.val   = 1'b1;
                we.nxt   = 1'b1;
                we.prv   = 1'b1;
                val_addr = new_slot[IW-1:0];
                nxt_addr = new_slot[IW-1:0];
                nxt_data = r_aft;
                prv_addr = new_slot[IW-1:0];
                prv_data = r_bef;
            end
            S_INSB: begin
                we.nxt = (r_bef != NULL_SLOT);
                we.prv = (r_aft != NULL_SLOT);
            end
            S_FIN: begin
                rd_addr = r_head[IW-1:0];
            end
            S_HD: begin
                rd_addr = r_tail[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NULL_SLOT;
            r_tail   <= NULL_SLOT;
            r_count  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_cmd   <= i_s_axis_tuser;
                        r_pos   <= i_s_axis_tdata[6:0];
                        r_val   <= i_s_axis_tdata[38:7];
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_status <= ST_INVALID;
                    r_readv  <= '0;
                    r_dir    <= loc_dir;
                    r_cur    <= loc_dir ? r_head : r_tail;
                    r_steps  <= loc_steps;
                    r_state  <= S_FIN;
                    if (r_cmd == CMD_CLEAR) begin
                        r_status <= ST_OK;
                        r_head   <= NULL_SLOT;
                        r_tail   <= NULL_SLOT;
                        r_count  <= '0;
                    end else if (is_ins) begin
                        if (ins_tgt > cnt_w) begin
                            r_status <= ST_INVALID;
                        end else if (r_count == LW'(CAPACITY)) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK;
                            if (r_count == '0) begin
                                r_bef   <= NULL_SLOT;
                                r_aft   <= NULL_SLOT;
                                r_state <= S_INSA;
                            end else if (ins_tgt == '0) begin
                                r_bef   <= NULL_SLOT;
                                r_aft   <= r_head;
                                r_state <= S_INSA;
                            end else if (ins_tgt == cnt_w) begin
                                r_bef   <= r_tail;
                                r_aft   <= NULL_SLOT;
                                r_state <= S_INSA;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                    end else if (is_del || r_cmd == CMD_GET || r_cmd == CMD_SET) begin
                        if (r_count != '0 && loc_tgt < cnt_w) begin
                            r_status <= ST_OK;
                            r_state  <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (r_steps != '0) begin
                        r_cur   <= link;
                        r_steps <= r_steps - LW'(1);
                    end else if (is_ins) begin
                        r_bef   <= r_cur;
                        r_aft   <= rd_nxt;
                        r_state <= S_INSA;
                    end else begin
                        if (r_cmd == CMD_GET) begin
                            r_readv <= rd_val32;
                        end
                        if (is_del) begin
                            if (rd_prv == NULL_SLOT) begin
                                r_head <= rd_nxt;
                            end
                            if (rd_nxt == NULL_SLOT) begin
                                r_tail <= rd_prv;
                            end
                            r_count <= r_count - LW'(1);
                        end
                        r_state <= S_FIN;
                    end
                end
                S_INSA: begin
                    r_new   <= new_slot;
                    r_state <= S_INSB;
                end
                S_INSB: begin
                    if (r_bef == NULL_SLOT) begin
                        r_head <= r_new;
                    end
                    if (r_aft == NULL_SLOT) begin
                        r_tail <= r_new;
                    end
                    r_count <= r_count + LW'(1);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_HD;
                end
                S_HD: begin
                    r_first <= (r_count != '0) ? rd_val32 : '0;
                    r_state <= S_TL;
                end
                S_TL: begin
                    r_last  <= (r_count != '0) ? rd_val32 : '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_o_last   <= r_last;
                        r_o_first  <= r_first;
                        r_o_readv  <= r_readv;
                        r_o_status <= r_status;
                        r_o_count  <= CNT_O_W'(r_count);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register valid: loaded from S_OUT, cleared on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && (!r_ovalid || i_m_axis_tready)) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(CAPACITY))
        else $error("element count beyond capacity");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count == '0) |-> (r_head == NULL_SLOT && r_tail == NULL_SLOT))
        else $error("empty list with live head or tail");

    a_nonempty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count != '0) |-> (r_head != NULL_SLOT && r_tail != NULL_SLOT))
        else $error("non-empty list with null head or tail");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output state");

endmodule

[sv/idll_node_mem.sv]
`timescale 1ns / 1ps
// Node pool: value, next and prev arrays, one registered read port.
// Depends on idll_pkg.
module idll_node_mem
    import idll_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  t_node_we                      i_we,
    input  logic [$clog2(CAPACITY)-1:0]   i_val_addr,
    input  logic [VALUE_BITS-1:0]         i_val_data,
    input  logic [$clog2(CAPACITY)-1:0]   i_nxt_addr,
    input  logic [$clog2(CAPACITY+1)-1:0] i_nxt_data,
    input  logic [$clog2(CAPACITY)-1:0]   i_prv_addr,
    input  logic [$clog2(CAPACITY+1)-1:0] i_prv_data,
    input  logic [$clog2(CAPACITY)-1:0]   i_rd_addr,
    output logic [VALUE_BITS-1:0]         o_rd_val,
    output logic [$clog2(CAPACITY+1)-1:0] o_rd_nxt,
    output logic [$clog2(CAPACITY+1)-1:0] o_rd_prv
);

    localparam int LW = $clog2(CAPACITY + 1);

    logic [VALUE_BITS-1:0] r_val_mem [CAPACITY];
    logic [LW-1:0]         r_nxt_mem [CAPACITY];
    logic [LW-1:0]         r_prv_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we.val) begin
            r_val_mem[i_val_addr] <= i_val_data;
        end
        if (i_we.nxt) begin
            r_nxt_mem[i_nxt_addr] <= i_nxt_data;
        end
        if (i_we.prv) begin
            r_prv_mem[i_prv_addr] <= i_prv_data;
        end
        o_rd_val <= r_val_mem[i_rd_addr];
        o_rd_nxt <= r_nxt_mem[i_rd_addr];
        o_rd_prv <= r_prv_mem[i_rd_addr];
    end

endmodule

[sv/idll_slot_alloc.sv]
`timescale 1ns / 1ps
// Slot allocator: high-water counter plus a stack of released slots.
// Depends on idll_pkg.
module idll_slot_alloc
    import idll_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_alloc_ctl                    i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]   i_push_slot,
    output logic [$clog2(CAPACITY+1)-1:0] o_slot
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    logic [IW-1:0] r_stack [CAPACITY];
    logic [LW-1:0] r_sp;
    logic [LW-1:0] r_hw;
    logic [IW-1:0] r_top;
    logic [LW-1:0] sp_m1;

    assign sp_m1  = r_sp - LW'(1);
    assign o_slot = (r_sp != '0) ? LW'(r_top) : r_hw;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_stack[r_sp[IW-1:0]] <= i_push_slot;
        end
        r_top <= r_stack[sp_m1[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_sp <= '0;
            r_hw <= '0;
        end else if (i_ctl.push) begin
            r_sp <= r_sp + LW'(1);
        end else if (i_ctl.pop) begin
            if (r_sp != '0) begin
                r_sp <= sp_m1;
            end else begin
                r_hw <= r_hw + LW'(1);
            end
        end
    end

    a_sp_le_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= r_hw)
        else $error("free stack deeper than allocated slots");

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= LW'(CAPACITY))
        else $error("high-water mark beyond pool");

endmodule
